// ----- rtl/core/lgas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgas_pkg
// Shared types, item codes, colors and cell rule for the life grid age engine.
// ----------------------------------------------------------------------------
package lgas_pkg;

  // Default grid size
  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;

  // Item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // ARGB colors
  localparam logic [31:0] ARGB_WHITE = 32'hFFFF_FFFF;
  localparam logic [31:0] ARGB_GREEN = 32'hFF00_FF00;
  localparam logic [31:0] ARGB_RED   = 32'hFFFF_0000;
  localparam logic [31:0] ARGB_BLUE  = 32'hFF00_00FF;
  localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;

  localparam logic [7:0] AGE_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col_index;
    logic [5:0] row_index;
    logic [7:0] age_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_age;
    logic [31:0] color_argb;
  } out_item_t;

  // Color of a cell by age
  function automatic logic [31:0] age_to_argb(input logic [7:0] age);
    logic [31:0] c;
    if (age == 8'd0) c = ARGB_BLACK;
    else if (age == 8'd1) c = ARGB_GREEN;
    else if (age == 8'd2) c = ARGB_BLUE;
    else if (age == 8'd3) c = ARGB_RED;
    else c = ARGB_WHITE;
    return c;
  endfunction

  // One generation of a single cell; n is the live neighbor count
  function automatic logic [7:0] next_age(input logic [7:0] age, input logic [3:0] n);
    logic [7:0] a;
    if (age != 8'd0) begin
      if (n == 4'd2 || n == 4'd3) a = (age == AGE_MAX) ? AGE_MAX : age + 8'd1;
      else a = 8'd0;
    end else begin
      a = (n == 4'd3) ? 8'd1 : 8'd0;
    end
    return a;
  endfunction

endpackage

// ----- rtl/core/life_grid_age_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_age_step
// Game of Life engine with per-cell age, held in two ping-pong cell banks.
// ----------------------------------------------------------------------------
// A write item goes straight into the current bank. A read item waits while
// the previous result still sits stalled in the output register; the read
// result lands in that register. A step item sweeps the current bank, one
// cell per cycle, plus one flush row and column and the pipeline drain, and
// writes the next generation into the other bank; then the banks swap. After
// reset the block clears the current bank, one entry a cycle, over all
// 2^(ceil(log2(GRID_WIDTH))+ceil(log2(GRID_HEIGHT))) entries (4096 for 64x64),
// and takes no item until then. Coordinates outside the grid are ignored on
// write and read back as a dead cell.
// ----------------------------------------------------------------------------
module life_grid_age_step
  import lgas_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  localparam int CB = $clog2(GRID_WIDTH);
  localparam int RB = $clog2(GRID_HEIGHT);
  localparam int AW = CB + RB;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_READ,
    ST_HOLD
  } state_t;

  state_t state;

  logic          cur_sel;
  logic [AW-1:0] clr_addr;
  logic          in_grid_q;
  logic [7:0]    hold_age;

  logic          accept, in_grid, slot_free, res_load;
  logic [AW-1:0] host_addr;
  logic          host_we;
  logic          step_start;
  logic [7:0]    cur_rdata, read_age;

  logic          sw_rd_en;
  logic [AW-1:0] sw_rd_addr;
  logic          sw_wr_en;
  logic [AW-1:0] sw_wr_addr;
  logic [7:0]    sw_wr_data;
  logic          sw_done;

  logic          bank_we    [2];
  logic [AW-1:0] bank_waddr [2];
  logic [7:0]    bank_wdata [2];
  logic [AW-1:0] bank_raddr [2];
  logic [7:0]    bank_rdata [2];

  // Input side decode
  always_comb begin
    item_stall = (state != ST_IDLE);
    accept     = item_valid && !item_stall;
    in_grid    = (int'(item.col_index) < GRID_WIDTH) && (int'(item.row_index) < GRID_HEIGHT);
    host_addr  = {RB'(item.row_index), CB'(item.col_index)};
    host_we    = accept && (item.kind == KIND_WRITE) && in_grid;
    step_start = accept && (item.kind == KIND_STEP);
    slot_free  = !result_valid || !result_stall;
    res_load   = slot_free && ((state == ST_READ) || (state == ST_HOLD));
    cur_rdata  = cur_sel ? bank_rdata[1] : bank_rdata[0];
    read_age   = in_grid_q ? cur_rdata : 8'd0;
  end

  // Bank port steering: current bank serves host, clear and sweep reads;
  // the other bank takes the sweep's next generation
  for (genvar b = 0; b < 2; b++) begin : g_bank
    always_comb begin
      if (cur_sel == 1'(b)) begin
        bank_we[b]    = host_we || (state == ST_CLEAR);
        bank_waddr[b] = (state == ST_CLEAR) ? clr_addr : host_addr;
        bank_wdata[b] = (state == ST_CLEAR) ? 8'd0 : item.age_value;
        bank_raddr[b] = (state == ST_STEP) ? sw_rd_addr : host_addr;
      end else begin
        bank_we[b]    = sw_wr_en;
        bank_waddr[b] = sw_wr_addr;
        bank_wdata[b] = sw_wr_data;
        bank_raddr[b] = sw_rd_addr;
      end
    end

    lgas_ram #(
      .WIDTH (8),
      .DEPTH (2 ** AW)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr[b]),
      .wdata (bank_wdata[b]),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  lgas_sweep #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (step_start),
    .rd_en   (sw_rd_en),
    .rd_addr (sw_rd_addr),
    .rd_data (cur_rdata),
    .wr_en   (sw_wr_en),
    .wr_addr (sw_wr_addr),
    .wr_data (sw_wr_data),
    .done    (sw_done)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cur_sel      <= 1'b0;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      // new result takes the slot, else a transfer empties it
      if (res_load) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            in_grid_q <= in_grid;
            if (item.kind == KIND_STEP) state <= ST_STEP;
            else if (item.kind == KIND_READ) state <= ST_READ;
          end
        end
        ST_STEP: begin
          if (sw_done) begin
            cur_sel <= !cur_sel;
            state   <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (slot_free) begin
            result.cell_age   <= read_age;
            result.color_argb <= age_to_argb(read_age);
            state             <= ST_IDLE;
          end else begin
            hold_age <= read_age;
            state    <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            result.cell_age   <= hold_age;
            result.color_argb <= age_to_argb(hold_age);
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/lgas_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lgas_sweep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgas_sweep
// One-generation sweep: raster scan of the current bank, line buffer for the
// two rows above, 3x3 live window and the cell rule, write into the next bank.
// ----------------------------------------------------------------------------
module lgas_sweep
  import lgas_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int CB  = $clog2(GRID_WIDTH),
  localparam int RB  = $clog2(GRID_HEIGHT),
  localparam int AW  = CB + RB
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          done
);

  localparam int CIW = $clog2(GRID_WIDTH + 1);
  localparam int RIW = $clog2(GRID_HEIGHT + 1);
  localparam logic [CIW-1:0] CI_LAST = CIW'(GRID_WIDTH);
  localparam logic [RIW-1:0] RI_LAST = RIW'(GRID_HEIGHT);

  // scan position, one column and one row past the grid to flush the window
  logic           running;
  logic [RIW-1:0] ri;
  logic [CIW-1:0] ci;
  logic           last;

  logic           s1_valid, s1_last;
  logic [RIW-1:0] s1_ri;
  logic [CIW-1:0] s1_ci;
  logic           s2_valid, s2_last;
  logic [RIW-1:0] s2_ri;
  logic [CIW-1:0] s2_ci;

  // line buffer entry: live bit two rows up, age one row up
  logic          lb_we;
  logic [CB-1:0] lb_waddr;
  logic [8:0]    lb_wdata;
  logic [8:0]    lb_rdata;

  logic       s1_col_in, s1_cell_in, top_live;
  logic [7:0] cur_age, mid_age;

  // window: index 0 newest column, 1 center, 2 oldest
  logic [2:0] win_top, win_mid, win_bot;
  logic [7:0] age0, age1;

  logic [3:0]     ncount;
  logic [RIW-1:0] ri_m1;
  logic [CIW-1:0] ci_m1;

  assign last = (ri == RI_LAST) && (ci == CI_LAST);

  // Scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      ri      <= '0;
      ci      <= '0;
    end else if (start) begin
      running <= 1'b1;
      ri      <= '0;
      ci      <= '0;
    end else if (running) begin
      if (ci == CI_LAST) begin
        ci <= '0;
        if (ri == RI_LAST) running <= 1'b0;
        else ri <= ri + 1'b1;
      end else begin
        ci <= ci + 1'b1;
      end
    end
  end

  // Read issue
  assign rd_en   = running && (ri < RI_LAST) && (ci < CI_LAST);
  assign rd_addr = {ri[RB-1:0], ci[CB-1:0]};

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= running;
      s2_valid <= s1_valid;
    end
    s1_ri   <= ri;
    s1_ci   <= ci;
    s1_last <= last;
    s2_ri   <= s1_ri;
    s2_ci   <= s1_ci;
    s2_last <= s1_last;
  end

  lgas_ram #(
    .WIDTH (9),
    .DEPTH (2 ** CB)
  ) u_line (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_waddr),
    .wdata (lb_wdata),
    .raddr (ci[CB-1:0]),
    .rdata (lb_rdata)
  );

  // Stage 1: new column, rows outside the grid read as dead
  always_comb begin
    s1_col_in  = s1_ci < CI_LAST;
    s1_cell_in = s1_col_in && (s1_ri < RI_LAST);
    cur_age    = s1_cell_in ? rd_data : 8'd0;
    top_live   = s1_col_in && (s1_ri >= RIW'(2)) && lb_rdata[8];
    mid_age    = (s1_col_in && (s1_ri != '0)) ? lb_rdata[7:0] : 8'd0;
    lb_we      = s1_valid && s1_col_in;
    lb_waddr   = s1_ci[CB-1:0];
    lb_wdata   = {(mid_age != 8'd0), cur_age};
  end

  // Window shift; the left edge starts dead on every row
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (s1_ci == '0) begin
        win_top <= {2'b00, top_live};
        win_mid <= {2'b00, (mid_age != 8'd0)};
        win_bot <= {2'b00, (cur_age != 8'd0)};
        age1    <= 8'd0;
      end else begin
        win_top <= {win_top[1:0], top_live};
        win_mid <= {win_mid[1:0], (mid_age != 8'd0)};
        win_bot <= {win_bot[1:0], (cur_age != 8'd0)};
        age1    <= age0;
      end
      age0 <= mid_age;
    end
  end

  // Stage 2: rule and write-back of the center cell
  always_comb begin
    ncount  = 4'($countones({win_top, win_bot, win_mid[2], win_mid[0]}));
    ri_m1   = s2_ri - 1'b1;
    ci_m1   = s2_ci - 1'b1;
    wr_en   = s2_valid && (s2_ri != '0) && (s2_ci != '0);
    wr_addr = {ri_m1[RB-1:0], ci_m1[CB-1:0]};
    wr_data = next_age(age1, ncount);
    done    = s2_valid && s2_last;
  end

endmodule

// ----- sim/lgas_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgas_checker
// Watches both channels of the life grid age engine. It keeps its own copy of
// the grid, applies every accepted write and step to it, predicts the age and
// color of every read, and compares each returned result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module lgas_checker
  import lgas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_stall,
  input  in_item_t  item,
  input  logic      result_valid,
  input  logic      result_stall,
  input  out_item_t result,
  output int        mismatch_count,
  output int        pending_reads
);

  localparam int COLS = GRID_WIDTH_DEF;
  localparam int ROWS = GRID_HEIGHT_DEF;

  // Grid copy, indexed [row][col]; scratch grid for one generation
  logic [7:0] age_grid  [ROWS][COLS];
  logic [7:0] next_grid [ROWS][COLS];

  out_item_t read_results_q [$];
  int        bad_count;

  // Color for a given age
  function automatic logic [31:0] color_for_age(input logic [7:0] age);
    case (age)
      8'd0:    return ARGB_BLACK;
      8'd1:    return ARGB_GREEN;
      8'd2:    return ARGB_BLUE;
      8'd3:    return ARGB_RED;
      default: return ARGB_WHITE;
    endcase
  endfunction

  // One generation over the whole grid; edges do not wrap
  task automatic evolve_grid();
    int live;
    int rr;
    int cc;
    logic [7:0] age;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < ROWS && cc >= 0 && cc < COLS &&
                age_grid[rr][cc] != 8'd0) begin
              live++;
            end
          end
        end
        age = age_grid[r][c];
        if (age != 8'd0) begin
          if (live == 2 || live == 3) next_grid[r][c] = (age == 8'hFF) ? 8'hFF : age + 8'd1;
          else next_grid[r][c] = 8'd0;
        end else begin
          next_grid[r][c] = (live == 3) ? 8'd1 : 8'd0;
        end
      end
    end
    age_grid = next_grid;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          age_grid[r][c] = 8'd0;
        end
      end
      read_results_q.delete();
      bad_count = 0;
    end else begin
      // Result transfer: compare with the oldest prediction
      if (result_valid && !result_stall) begin
        if (read_results_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("%0t: unexpected result age %0d argb %h", $realtime,
                     result.cell_age, result.color_argb);
          end
        end else begin
          want = read_results_q.pop_front();
          if (result.cell_age !== want.cell_age || result.color_argb !== want.color_argb) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: read mismatch: expected age %0d argb %h, got age %0d argb %h",
                       $realtime, want.cell_age, want.color_argb,
                       result.cell_age, result.color_argb);
            end
          end
        end
      end
      // Item transfer: update the grid copy or queue a prediction
      if (item_valid && !item_stall) begin
        case (item.kind)
          KIND_WRITE: age_grid[item.row_index][item.col_index] = item.age_value;
          KIND_STEP:  evolve_grid();
          KIND_READ: begin
            pred.cell_age   = age_grid[item.row_index][item.col_index];
            pred.color_argb = color_for_age(pred.cell_age);
            read_results_q.push_back(pred);
          end
          default: ;  // unused kind is dropped by the block
        endcase
      end
    end
    mismatch_count <= bad_count;
    pending_reads  <= read_results_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the life grid age engine. Drives a directed set of writes,
// reads and steps (corners, saturation, births, edges that do not wrap, the
// unused kind), then random pattern seeding around a moving window with reads
// and steps. The sender works in bursts, the receiver stalls on its own
// pattern; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import lgas_pkg::*;

  localparam int RANDOM_ITEMS = 110;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 4400;  // longer than one full step sweep

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item;
  logic      result_valid;
  logic      result_stall;
  out_item_t result;

  int mismatch_count;
  int pending_reads;
  int cycle_count = 0;
  int burst_left;
  int stall_mode;
  int stall_left;

  life_grid_age_step uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  lgas_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .mismatch_count (mismatch_count),
    .pending_reads  (pending_reads)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stall pattern: phases of no stall, random stall, mostly stalled
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode   <= 0;
      stall_left   <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= 1'($urandom_range(0, 1));
        default: result_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One item transfer, then either stay in the burst or idle for a gap
  task automatic push_item(input logic [1:0] k, input logic [5:0] c, input logic [5:0] r,
                           input logic [7:0] a);
    in_item_t it;
    int gap;
    it.kind      = k;
    it.col_index = c;
    it.row_index = r;
    it.age_value = a;
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int sent;
    int pick;
    int win_col;
    int win_row;
    logic [5:0] c;
    logic [5:0] r;
    logic [7:0] a;

    burst_left  = 0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Corners and every color
    push_item(KIND_WRITE, 6'd0, 6'd0, 8'd255);
    push_item(KIND_WRITE, 6'd63, 6'd63, 8'd1);
    push_item(KIND_WRITE, 6'd63, 6'd0, 8'd2);
    push_item(KIND_WRITE, 6'd0, 6'd63, 8'd3);
    push_item(KIND_WRITE, 6'd10, 6'd10, 8'd4);
    push_item(KIND_READ, 6'd0, 6'd0, 8'd0);
    push_item(KIND_READ, 6'd63, 6'd63, 8'd255);
    push_item(KIND_READ, 6'd63, 6'd0, 8'd0);
    push_item(KIND_READ, 6'd0, 6'd63, 8'd0);
    push_item(KIND_READ, 6'd10, 6'd10, 8'd0);
    push_item(KIND_READ, 6'd32, 6'd32, 8'd0);
    // Unused kind with every field bit set must change nothing
    push_item(2'd3, 6'd63, 6'd63, 8'd255);
    push_item(KIND_READ, 6'd63, 6'd63, 8'd0);
    // Block in the corner near saturation, blinker against the right edge
    push_item(KIND_WRITE, 6'd1, 6'd0, 8'd254);
    push_item(KIND_WRITE, 6'd0, 6'd1, 8'd254);
    push_item(KIND_WRITE, 6'd1, 6'd1, 8'd1);
    push_item(KIND_WRITE, 6'd63, 6'd5, 8'd7);
    push_item(KIND_WRITE, 6'd63, 6'd6, 8'd7);
    push_item(KIND_WRITE, 6'd63, 6'd7, 8'd7);
    // Step with junk in the unused fields
    push_item(KIND_STEP, 6'd63, 6'd63, 8'd255);
    push_item(KIND_READ, 6'd0, 6'd0, 8'd0);
    push_item(KIND_READ, 6'd1, 6'd1, 8'd0);
    push_item(KIND_READ, 6'd62, 6'd6, 8'd0);
    push_item(KIND_READ, 6'd63, 6'd5, 8'd0);
    push_item(KIND_READ, 6'd10, 6'd10, 8'd0);

    // Random seeding around a window, with steps and reads
    win_col = 0;
    win_row = 0;
    sent    = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
        c = 6'(win_col + $urandom_range(0, 7));
        r = 6'(win_row + $urandom_range(0, 7));
      end else begin
        c = 6'($urandom_range(0, 63));
        r = 6'($urandom_range(0, 63));
      end
      case ($urandom_range(0, 3))
        0:       a = 8'd0;
        1:       a = 8'($urandom_range(1, 4));
        2:       a = 8'($urandom_range(250, 255));
        default: a = 8'($urandom_range(0, 255));
      endcase
      if (pick < 8) begin
        push_item(KIND_STEP, c, r, a);
        sent++;
        // Occasionally move the window, often onto an edge
        if ($urandom_range(0, 2) == 0) begin
          win_col = ($urandom_range(0, 3) == 0) ? 56 * $urandom_range(0, 1)
                                                 : $urandom_range(0, 56);
          win_row = ($urandom_range(0, 3) == 0) ? 56 * $urandom_range(0, 1)
                                                 : $urandom_range(0, 56);
        end
      end else if (pick < 12) begin
        push_item(2'd3, c, r, a);
      end else if (pick < 55) begin
        push_item(KIND_WRITE, c, r, a);
        sent++;
      end else begin
        push_item(KIND_READ, c, r, a);
        sent++;
      end
    end
    item_valid <= 1'b0;

    // Wait for every read result, then let any sweep in flight finish
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_reads == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
